>>> hdl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest unit package
// Shared request/response types, sequencer states and hash constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} digest_t;

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} seq_state_t;

	localparam int unsigned HASH_WORDS  = 5;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 80;

	localparam logic [31:0] H_INIT [HASH_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [2:0] LAST_EMIT  = 3'(HASH_WORDS - 1);

endpackage

>>> hdl/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest unit
// Byte-serial SHA-1: gathers bytes, compresses blocks with one round per
// cycle, pads the final block(s) and returns the five digest words.
// ----------------------------------------------------------------------------
// Usage: send one request per message byte (byte_valid set) and mark the last
// request with end_of_message; a request with byte_valid clear and
// end_of_message set ends a message without adding a byte (this is how an
// empty message is hashed). The 64th byte of a block starts a compression
// of 80 rounds (one round per cycle on a single shared round datapath)
// followed by the chaining add, during which msg_ready is low. After
// end_of_message the unit feeds the 0x80 pad, zero bytes and the 64-bit
// big-endian bit count through the same byte path at one byte per cycle,
// compresses one or two final blocks, then presents the five digest words
// H0..H4 on the digest port, one per cycle when digest_ready stays high,
// with last_word marking H4. Once the fifth word is loaded into the output
// register the unit re-initializes and accepts the next message while that
// word still waits to be taken. The bit count wraps modulo 2^64.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit
	import sha1_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	output logic    msg_ready,
	input  msg_t    msg,
	output logic    digest_valid,
	input  logic    digest_ready,
	output digest_t digest
);

	// Sequencer state and message bookkeeping
	seq_state_t state_q, state_d;
	logic [5:0]  pos_q;       // byte position inside the current block
	logic [63:0] cnt_q;       // message length in bits
	logic [6:0]  rnd_q;       // round counter during compression
	logic [2:0]  emit_q;      // digest word being loaded
	logic        pad_q;       // message ended, padding pending or running
	logic        sent80_q;    // 0x80 pad byte already pushed
	logic        len_q;       // length field being pushed
	logic        fin_q;       // last block compression under way

	// Datapath storage
	logic [31:0] h_q    [HASH_WORDS];   // chaining value
	logic [31:0] work_q [HASH_WORDS];   // round registers a..e
	logic [31:0] sched_q[BLOCK_WORDS];  // block bytes, then schedule window

	logic        out_valid_q;
	digest_t     out_q;

	// Control decoded from the state
	logic        fire;
	logic        push_byte;
	logic [7:0]  push_val;
	logic        start_blk;
	logic        count_inc;
	logic        emit_load;
	logic        len_now;
	logic [7:0]  len_byte;
	logic [7:0]  pad_val;

	// Round datapath
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic [31:0] t_val;

	assign fire = msg_valid && msg_ready;

	// Length bytes go out most significant first at positions 56..63.
	assign len_byte = 8'(cnt_q >> {~pos_q[2:0], 3'b000});
	// Length starts only after the pad byte, once a block reaches position 56.
	assign len_now  = len_q || (sent80_q && (pos_q == LEN_POS));
	assign pad_val  = !sent80_q ? PAD_BYTE : (len_now ? len_byte : 8'h00);

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (fire) begin
					if (msg.byte_valid && (pos_q == LAST_POS)) begin
						state_d = ST_ROUND;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (fin_q) begin
					state_d = ST_EMIT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_ACCEPT;
				end
			end
			ST_PAD: begin
				if (pos_q == LAST_POS) begin
					state_d = ST_ROUND;
				end
			end
			ST_EMIT: begin
				if (emit_load && (emit_q == LAST_EMIT)) begin
					state_d = ST_ACCEPT;
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	// ------------------------------------------------------------------
	// Control outputs of the sequencer
	// ------------------------------------------------------------------
	always_comb begin
		msg_ready = 1'b0;
		push_byte = 1'b0;
		push_val  = msg.data_byte;
		count_inc = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				msg_ready = 1'b1;
				push_byte = fire && msg.byte_valid;
				count_inc = fire && msg.byte_valid;
			end
			ST_PAD: begin
				push_byte = 1'b1;
				push_val  = pad_val;
			end
			ST_EMIT: begin
				emit_load = !out_valid_q || digest_ready;
			end
			ST_ROUND, ST_ADD: begin
			end
			default: begin
			end
		endcase
	end

	// A byte landing on the last position fills the block: start compression.
	assign start_blk = push_byte && (pos_q == LAST_POS);

	// ------------------------------------------------------------------
	// Round function: one SHA-1 round per cycle
	// ------------------------------------------------------------------
	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			k_val = K_R0;
		end else if (rnd_q < 7'd40) begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = K_R1;
		end else if (rnd_q < 7'd60) begin
			f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3])
				| (work_q[2] & work_q[3]);
			k_val = K_R2;
		end else begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = K_R3;
		end
	end

	// Window slot 0 holds W[t-16]; slots 2, 8 and 13 hold W[t-14], W[t-8], W[t-3].
	assign w_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w_new = (rnd_q < 7'd16) ? sched_q[0] : {w_mix[30:0], w_mix[31]};
	assign t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4]
		+ k_val + w_new;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			pos_q       <= '0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			emit_q      <= '0;
			pad_q       <= 1'b0;
			sent80_q    <= 1'b0;
			len_q       <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// advance the byte position on every pushed byte, wrapping at 64
			if (push_byte) begin
				pos_q <= pos_q + 6'd1;
			end
			if (count_inc) begin
				cnt_q <= cnt_q + 64'd8;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= (rnd_q == LAST_ROUND) ? '0 : rnd_q + 7'd1;
			end
			if (fire && msg.end_of_message) begin
				pad_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				sent80_q <= 1'b1;
				if (len_now) begin
					len_q <= 1'b1;
				end
				if (len_now && (pos_q == LAST_POS)) begin
					fin_q <= 1'b1;
				end
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_load) begin
				if (emit_q == LAST_EMIT) begin
					// message done: drop all message state for the next one
					emit_q   <= '0;
					cnt_q    <= '0;
					pad_q    <= 1'b0;
					sent80_q <= 1'b0;
					len_q    <= 1'b0;
					fin_q    <= 1'b0;
				end else begin
					emit_q <= emit_q + 3'd1;
				end
			end
		end
	end

	// Chaining value: reset to the initial constants, updated per block,
	// rotated out word by word during emission, re-initialized afterwards.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else if (state_q == ST_ADD) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				h_q[i] <= h_q[i] + work_q[i];
			end
		end else if (emit_load) begin
			if (emit_q == LAST_EMIT) begin
				for (int i = 0; i < HASH_WORDS; i++) begin
					h_q[i] <= H_INIT[i];
				end
			end else begin
				for (int i = 0; i < HASH_WORDS - 1; i++) begin
					h_q[i] <= h_q[i + 1];
				end
				h_q[HASH_WORDS - 1] <= h_q[0];
			end
		end
	end

	// Payload registers: block/schedule window, round registers, output word
	always_ff @(posedge clk) begin
		if (push_byte) begin
			// shift the whole block left by one byte, new byte at the tail
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				sched_q[i] <= {sched_q[i][23:0], sched_q[i + 1][31:24]};
			end
			sched_q[BLOCK_WORDS - 1] <= {sched_q[BLOCK_WORDS - 1][23:0], push_val};
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[BLOCK_WORDS - 1] <= w_new;
		end

		if (start_blk) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				work_q[i] <= h_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			work_q[0] <= t_val;
			work_q[1] <= work_q[0];
			work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3];
		end

		if (emit_load) begin
			out_q.digest_word <= h_q[0];
			out_q.last_word   <= (emit_q == LAST_EMIT);
		end
	end

	assign digest_valid = out_valid_q;
	assign digest       = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (rnd_q == LAST_ROUND) |=> (state_q == ST_ADD))
		else $error("compression did not end after the last round");

	a_rnd_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (rnd_q == '0))
		else $error("round counter not zero outside compression");

	a_emit_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pos_q == '0) && fin_q)
		else $error("digest emitted before the final block completed");

	a_pad_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> pad_q)
		else $error("padding without an ended message");

	a_fin_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (len_q && sent80_q))
		else $error("final block flagged before length field");

endmodule

>>> bench/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the request and digest channels, hashes every accepted request in
// its own copy of the unit state and compares each digest word against it.
// ----------------------------------------------------------------------------
module sha1_digest_checker
	import sha1_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	input  logic    msg_ready,
	input  msg_t    msg,
	input  logic    digest_valid,
	input  logic    digest_ready,
	input  digest_t digest,
	output int      words_pending,
	output int      mismatch_count
);

	localparam int unsigned REPORT_LIMIT = 10;

	logic [31:0] chain [HASH_WORDS];
	logic [31:0] blk [BLOCK_WORDS];
	logic [5:0]  pos;
	logic [63:0] bit_count;
	digest_t     expected_words [$];

	function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// 80 rounds over the block buffer, then fold into the chaining value.
	function automatic void compress_buffer();
		logic [31:0] w [BLOCK_WORDS];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int unsigned r;
		for (r = 0; r < BLOCK_WORDS; r++)
			w[r] = blk[r];
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (r = 0; r < ROUNDS; r++) begin
			if (r >= 16) begin
				x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
				w[r % 16] = rol(x, 1);
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rol(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	// Place one byte big-endian; a full block is compressed right away.
	function automatic void load_byte(input logic [7:0] value);
		blk[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] = value;
		if (pos == LAST_POS)
			compress_buffer();
		pos = pos + 6'd1;
	endfunction

	function automatic void absorb_request(input msg_t m);
		logic [63:0] len;
		digest_t     word;
		int unsigned i;
		if (m.byte_valid) begin
			bit_count += 64'd8;
			load_byte(m.data_byte);
		end
		if (m.end_of_message) begin
			len = bit_count;
			load_byte(PAD_BYTE);
			while (pos != LEN_POS)
				load_byte(8'h00);
			for (i = 0; i < 8; i++)
				load_byte(len[63 - 8 * i -: 8]);
			for (i = 0; i < HASH_WORDS; i++) begin
				word.digest_word = chain[i];
				word.last_word   = (i == HASH_WORDS - 1);
				expected_words.push_back(word);
			end
			for (i = 0; i < HASH_WORDS; i++)
				chain[i] = H_INIT[i];
			pos       = '0;
			bit_count = '0;
		end
	endfunction

	function automatic void note_mismatch(input string what, input digest_t want,
		input digest_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t ns: %s: expected %h last %0b, got %h last %0b", $time, what,
				want.digest_word, want.last_word, got.digest_word, got.last_word);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_t want;
		if (!arst_n) begin
			for (int unsigned i = 0; i < HASH_WORDS; i++)
				chain[i] = H_INIT[i];
			for (int unsigned i = 0; i < BLOCK_WORDS; i++)
				blk[i] = '0;
			pos            = '0;
			bit_count      = '0;
			mismatch_count = 0;
			expected_words.delete();
		end else begin
			if (digest_valid && digest_ready) begin
				if (expected_words.size() == 0) begin
					want = '0;
					note_mismatch("digest word with nothing expected", want, digest);
				end else begin
					want = expected_words.pop_front();
					if (digest.digest_word !== want.digest_word ||
						digest.last_word !== want.last_word)
						note_mismatch("digest word differs", want, digest);
				end
			end
			if (msg_valid && msg_ready)
				absorb_request(msg);
		end
		words_pending = expected_words.size();
	end

endmodule

>>> bench/tb_sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest unit testbench
// Feeds byte requests that form whole messages, directed ones first and then
// random lengths, mostly short with some at the block and pad boundaries, under three
// idle patterns on the two channels; a checker beside the unit predicts and
// compares every digest word.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_unit;
	import sha1_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned DRAIN_CYCLES    = 300;
	localparam int unsigned RANDOM_REQUESTS = 220;
	localparam int unsigned PHASES          = 3;

	// Lengths that land the pad exactly at, just before and just past the
	// length field, fill a block exactly, or span two blocks.
	localparam int unsigned EDGE_LENS [8] = '{55, 56, 57, 62, 63, 64, 65, 128};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    msg_valid = 1'b0;
	logic    msg_ready;
	msg_t    msg = '0;
	logic    digest_valid;
	logic    digest_ready = 1'b0;
	digest_t digest;

	int          words_pending;
	int          mismatch_count;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned counted_requests = 0;
	int unsigned cycle_count = 0;

	sha1_message_digest_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	sha1_digest_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.msg            (msg),
		.digest_valid   (digest_valid),
		.digest_ready   (digest_ready),
		.digest         (digest),
		.words_pending  (words_pending),
		.mismatch_count (mismatch_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Receiver: decide once per falling edge whether to take a digest word.
	always @(negedge clk) begin
		digest_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Watchdog: give up on a hung unit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sha1_message_digest_unit: mismatch");
			$finish;
		end
	end

	// Present one request at a falling edge and hold it until it is taken.
	// Valid stays high between back-to-back requests; it only drops for a gap.
	task automatic send_req(input logic [7:0] data, input logic valid_byte,
		input logic last);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid <= 1'b1;
		msg       <= '{data_byte: data, byte_valid: valid_byte, end_of_message: last};
		do
			@(posedge clk);
		while (!msg_ready);
		counted_requests++;
	endtask

	// One whole message of len bytes with random content. Sprinkle ignored
	// requests in between, and close either on the last byte or with a
	// separate byte-less closing request.
	task automatic send_message(input int unsigned len);
		int unsigned i;
		logic        close_on_byte;
		close_on_byte = (len != 0) && ($urandom_range(1, 0) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(7, 0) == 0)
				send_req(8'($urandom), 1'b0, 1'b0);
			send_req(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
		end
		if (!close_on_byte)
			send_req(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int unsigned phase;
		int unsigned len;
		int unsigned target;

		// Reset is held from time zero and released at a falling edge.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 36;
		recv_idle_pct = 85;

		// Empty message: close with no byte at all.
		send_req(8'h00, 1'b0, 1'b1);
		// "abc", closed on its last byte.
		send_req(8'h61, 1'b1, 1'b0);
		send_req(8'h62, 1'b1, 1'b0);
		send_req(8'h63, 1'b1, 1'b1);
		// Ignored bytes in the middle, extreme byte values, close with no byte.
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'h00, 1'b1, 1'b0);
		send_req(8'hFF, 1'b1, 1'b0);
		send_req(8'h5A, 1'b0, 1'b0);
		send_req(8'h80, 1'b1, 1'b0);
		send_req(8'hA5, 1'b0, 1'b1);
		// Back-to-back empty message checks re-initialization.
		send_req(8'hFF, 1'b0, 1'b1);
		// Single-byte messages at both extremes.
		send_req(8'hFF, 1'b1, 1'b1);
		send_req(8'h00, 1'b1, 1'b1);
		// The 2^64 bit-count wrap needs 2^61 bytes and is out of reach here.

		counted_requests = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target = (phase + 1) * RANDOM_REQUESTS / PHASES;
			while (counted_requests < target) begin
				// Mostly short messages, a fifth at the block boundaries.
				if ($urandom_range(9, 0) < 8)
					len = $urandom_range(12, 0);
				else
					len = EDGE_LENS[$urandom_range(7, 0)];
				// Trim the last message of a phase to the remaining budget.
				if (len > target - counted_requests)
					len = target - counted_requests;
				send_message(len);
			end
		end

		@(negedge clk);
		msg_valid <= 1'b0;

		// Drain: wait for every expected word, then watch for strays.
		while (words_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("sha1_message_digest_unit: match");
		else
			$display("sha1_message_digest_unit: mismatch");
		$finish;
	end

endmodule
